### design/gwm_pkg.sv
// Shared types, constants and the case-folding function for the wildcard
// glob matcher. No dependencies; used by gwm_cell and the top level.
package gwm_pkg;

  localparam int PATTERN_LEN_DEF = 64;

  localparam logic [7:0] WILD_RUN = 8'h2A;
  localparam logic [7:0] WILD_ONE = 8'h3F;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_TEXT   = 2'd2,
    ACT_END    = 2'd3
  } action_t;

  // Broadcast controls from the top level to every cell.
  typedef struct packed {
    logic text;
    logic rearm;
    logic wr;
  } ctl_t;

  // Data a cell hands to its right neighbor.
  typedef struct packed {
    logic open;   // active and holding a '*': the next position is live too
    logic adv;    // live, consumed the current text byte, advances
  } link_t;

  function automatic logic [7:0] fold_upper(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7A) begin
      r = c - 8'h20;
    end
    return r;
  endfunction

endpackage

### design/gwm_cell.sv
// One pattern position of the matcher: its stored byte and its active bit.
// Depends on gwm_pkg; chained from left to right by the top level.
module gwm_cell #(
  parameter int IDX = 0,
  parameter int CW  = 7
) (
  input  logic           clk,
  input  logic           rst,
  input  gwm_pkg::ctl_t  ctl,
  input  logic [CW-1:0]  wr_idx,
  input  logic [7:0]     wr_byte,
  input  logic [7:0]     text_byte,
  input  logic [CW-1:0]  stored_count,
  input  gwm_pkg::link_t link_in,
  output gwm_pkg::link_t link_out,
  output logic           live
);
  import gwm_pkg::*;

  logic [7:0] pbyte;
  logic       active;
  logic       active_next;
  logic       valid;
  logic       star;
  logic       hit;

  // The store holds at most one '*' in a row, so closure spans one cell.
  assign valid = stored_count > CW'(IDX);
  assign star  = pbyte == WILD_RUN;
  assign hit   = (pbyte == WILD_ONE) || (pbyte == text_byte);
  assign live  = active || link_in.open;

  assign link_out.open = active && valid && star;
  assign link_out.adv  = live && valid && !star && hit;

  always_comb begin
    active_next = active;
    if (ctl.rearm) begin
      active_next = (IDX == 0);
    end else if (ctl.text) begin
      active_next = (live && valid && star) || link_in.adv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= (IDX == 0);
    end else begin
      active <= active_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr && wr_idx == CW'(IDX)) begin
      pbyte <= wr_byte;
    end
  end

endmodule

### design/wildcard_glob_matcher_top.sv
// Top level of the case-insensitive wildcard glob matcher: pattern load
// control, the row of gwm_cell positions and the result register.
// Depends on gwm_pkg and gwm_cell.
//
//   channel  signals                              moves
//   in       in_valid in_ready action char_byte   one command or text byte
//   out      out_valid out_ready matched          one end-of-text result
//            pattern_overflowed
//
// All positions update in parallel in the cell row, so one text byte is
// consumed per clock with no bubbles.
// The result of an end-of-text transfer appears in the output register in the
// next cycle. While that result waits, further non-end items are taken;
// only another end-of-text item stalls. Synchronous reset empties the
// pattern, clears the overflow flag and arms the start position.
module wildcard_glob_matcher_top #(
  parameter int PATTERN_LEN = gwm_pkg::PATTERN_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] action,
  input  logic [7:0] char_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       matched,
  output logic       pattern_overflowed
);
  import gwm_pkg::*;

  localparam int CW = $clog2(PATTERN_LEN + 1);

  action_t       act;
  logic          accept;
  logic [7:0]    folded;
  logic          is_star;
  ctl_t          ctl;
  logic [CW-1:0] raw_count;
  logic [CW-1:0] stored_count;
  logic          last_star;
  logic          overflow;
  link_t         links [PATTERN_LEN+1:0];
  logic [PATTERN_LEN:0] live;

  assign act      = action_t'(action);
  assign in_ready = !out_valid || out_ready || (act != ACT_END);
  assign accept   = in_valid && in_ready;
  assign folded   = fold_upper(char_byte);
  assign is_star  = folded == WILD_RUN;

  // A '*' right after a stored '*' is counted but not stored; the two match
  // the same texts.
  always_comb begin
    ctl.text  = accept && (act == ACT_TEXT);
    ctl.rearm = accept && (act != ACT_TEXT);
    ctl.wr    = accept && (act == ACT_APPEND) && (raw_count < CW'(PATTERN_LEN))
                && !(is_star && last_star);
  end

  assign links[0] = '0;

  for (genvar g = 0; g <= PATTERN_LEN; g++) begin : g_cell
    gwm_cell #(
      .IDX (g),
      .CW  (CW)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctl          (ctl),
      .wr_idx       (stored_count),
      .wr_byte      (folded),
      .text_byte    (folded),
      .stored_count (stored_count),
      .link_in      (links[g]),
      .link_out     (links[g+1]),
      .live         (live[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_count    <= '0;
      stored_count <= '0;
      last_star    <= 1'b0;
      overflow     <= 1'b0;
    end else if (accept) begin
      case (act)
        ACT_CLEAR: begin
          raw_count    <= '0;
          stored_count <= '0;
          last_star    <= 1'b0;
          overflow     <= 1'b0;
        end
        ACT_APPEND: begin
          if (raw_count < CW'(PATTERN_LEN)) begin
            raw_count <= raw_count + 1'b1;
            if (ctl.wr) begin
              stored_count <= stored_count + 1'b1;
              last_star    <= is_star;
            end
          end else begin
            overflow <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && act == ACT_END) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && act == ACT_END) begin
      matched            <= live[stored_count];
      pattern_overflowed <= overflow;
    end
  end

`ifndef SYNTHESIS
  a_stored_le_raw: assert property (@(posedge clk) disable iff (rst)
    stored_count <= raw_count)
    else $error("stored count exceeds raw pattern count");

  a_raw_bound: assert property (@(posedge clk) disable iff (rst)
    raw_count <= CW'(PATTERN_LEN))
    else $error("raw pattern count beyond store depth");

  a_star_needs_byte: assert property (@(posedge clk) disable iff (rst)
    last_star |-> stored_count != '0)
    else $error("last-star flag set with empty store");

  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept && act == ACT_END |=> out_valid)
    else $error("end-of-text transfer produced no result");

  a_full_drops: assert property (@(posedge clk) disable iff (rst)
    accept && act == ACT_APPEND && raw_count == CW'(PATTERN_LEN) |=> overflow)
    else $error("append to a full store did not flag overflow");
`endif

endmodule
